>>> src/rcm_pkg.sv
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared types, sizes and codes for the rate-of-change momentum block.
// ----------------------------------------------------------------------------
package rcm_pkg;

    localparam int RING_DEPTH = 64;
    localparam int PRICE_BITS = 32;

    localparam int PRICE_IN_W  = 32;
    localparam int LOOKBACK_W  = 6;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int PCT_W       = 32;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > LOOKBACK_W) ? CNT_W : LOOKBACK_W) + 1;

    // scale from a price ratio to 1/10000 percent
    localparam int          SCALE_W   = 20;
    localparam logic [19:0] PCT_SCALE = 20'd1000000;

    localparam int NUM_W  = PRICE_BITS + SCALE_W;
    localparam int QUOT_W = 32;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int FLAT_W = (PRICE_BITS > CFG_DATA_W) ? PRICE_BITS : CFG_DATA_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_LOOKBACK = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EPSILON  = 1'd1;

    typedef struct packed {
        logic                  close_present;
        logic [PRICE_IN_W-1:0] close_price;
    } close_item_t;

    typedef struct packed {
        logic                    history_ready;
        logic [PRICE_IN_W-1:0]   comparison_close;
        logic signed [PCT_W-1:0] percent_change;
        logic                    is_flat;
        logic                    is_rising;
    } result_item_t;

    // one classified close, handed from the front to the back
    typedef struct packed {
        logic                  ready;
        logic [PRICE_BITS-1:0] latest;
        logic [PRICE_BITS-1:0] comp;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_FINISH
    } back_state_t;

endpackage

>>> src/rate_of_change_momentum.sv
// ----------------------------------------------------------------------------
// rate_of_change_momentum
// Rate-of-change momentum over a stream of closing prices.
// ----------------------------------------------------------------------------
// close_valid/close_ready carry one request per row: a present flag and a
// close in 1/10000 currency units. Rows with no close or a zero close are
// taken and dropped without a result. Every kept close yields one request on
// result_valid/result_ready with the history flag, the close lookback
// sessions back, the signed change in 1/10000 percent and flat/rising flags.
// cfg_we/cfg_index/cfg_data write lookback_sessions (index 0) and
// flat_epsilon (index 1); the user must do so only while the block is
// idle, as the block itself does not enforce it. The front stores the close
// and fetches the comparison close from the ring into registers; the back
// then does the scale multiply and runs the bit-serial divider, while a
// close with too little history skips both. The back works on one close at
// a time and takes no new one until it has loaded the result of the last.
// A two-entry queue sits between front and back, and the result register lets
// the next close proceed while a result waits; a stalled receiver only holds
// the back once the result register and its finished work are both waiting.
// Reset empties the ring history (fill count and write pointer to zero) and
// sets lookback to 7 and epsilon to 0; ring contents need no clearing.
// ----------------------------------------------------------------------------
module rate_of_change_momentum (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               close_valid,
    output logic                               close_ready,
    input  rcm_pkg::close_item_t               close_item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output rcm_pkg::result_item_t              result_item,
    input  logic                               cfg_we,
    input  logic [rcm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rcm_pkg::*;

    logic [LOOKBACK_W-1:0] lookback_reg;
    logic [CFG_DATA_W-1:0] epsilon_reg;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic pop_valid;
    logic pop_ready;
    job_t pop_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lookback_reg <= LOOKBACK_W'(7);
            epsilon_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LOOKBACK: lookback_reg <= cfg_data[LOOKBACK_W-1:0];
                CFG_EPSILON:  epsilon_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rcm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .close_valid (close_valid),
        .close_ready (close_ready),
        .close_item  (close_item),
        .lookback    (lookback_reg),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_job    (push_job)
    );

    rcm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    rcm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_job      (pop_job),
        .flat_epsilon (epsilon_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // a result without history carries nothing else
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.history_ready |->
        (result_item.comparison_close == '0) && (result_item.percent_change == '0)
        && !result_item.is_flat && !result_item.is_rising)
    else $error("result without history carries data");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result_item.is_flat && result_item.is_rising))
    else $error("result both flat and rising");

    // a rise never reports a negative change
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.is_rising |-> !result_item.percent_change[PCT_W-1])
    else $error("rising result with negative change");

    // a fall never reports a positive change
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.history_ready && !result_item.is_flat
        && !result_item.is_rising |->
        (result_item.percent_change[PCT_W-1] || (result_item.percent_change == '0)))
    else $error("falling result with positive change");

endmodule

>>> src/rcm_queue.sv
// ----------------------------------------------------------------------------
// rcm_queue
// Short queue of classified closes between the front and the back.
// ----------------------------------------------------------------------------
module rcm_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  rcm_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output rcm_pkg::job_t pop_job
);
    import rcm_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> src/rcm_front.sv
// ----------------------------------------------------------------------------
// rcm_front
// Accepts closes, drops empty rows, keeps the close ring and fill count,
// and fetches the comparison close for each kept close.
// ----------------------------------------------------------------------------
module rcm_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               close_valid,
    output logic                               close_ready,
    input  rcm_pkg::close_item_t               close_item,
    input  logic [rcm_pkg::LOOKBACK_W-1:0]     lookback,
    output logic                               push_valid,
    input  logic                               push_ready,
    output rcm_pkg::job_t                      push_job
);
    import rcm_pkg::*;

    logic [PRICE_BITS-1:0] ring [RING_DEPTH];

    logic [PTR_W-1:0]      wr_ptr_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic                  stage_valid_reg;
    logic                  stage_ready_reg;
    logic [PRICE_BITS-1:0] stage_latest_reg;
    logic [PRICE_BITS-1:0] comp_rd_reg;

    logic [PRICE_BITS-1:0] latest;
    logic                  accept;
    logic                  keep;
    logic [CNT_W-1:0]      fill_next;
    logic [CMP_W-1:0]      look_ext;
    logic [CMP_W-1:0]      fill_ext;
    logic [CMP_W-1:0]      slot_ext;
    logic [CMP_W-1:0]      back_idx;
    logic [PTR_W-1:0]      comp_idx;
    logic                  hist_ready;

    // price masked or widened to the ring width
    always_comb
    begin
        for (int i = 0; i < PRICE_BITS; i++)
        begin
            latest[i] = (i < PRICE_IN_W) ? close_item.close_price[i] : 1'b0;
        end
    end

    assign close_ready = !stage_valid_reg || push_ready;
    assign accept      = close_valid && close_ready;
    assign keep        = accept && close_item.close_present && (latest != '0);

    assign fill_next  = (fill_reg < CNT_W'(RING_DEPTH)) ? fill_reg + 1'b1 : fill_reg;
    assign look_ext   = CMP_W'(lookback);
    assign fill_ext   = CMP_W'(fill_next);
    assign slot_ext   = CMP_W'(wr_ptr_reg);
    assign hist_ready = (look_ext != '0) && (look_ext < CMP_W'(RING_DEPTH))
                        && (fill_ext > look_ext);

    // slot of the close lookback entries back, wrapping around the ring
    assign back_idx = (slot_ext >= look_ext) ? (slot_ext - look_ext)
                                             : (slot_ext + CMP_W'(RING_DEPTH) - look_ext);
    assign comp_idx = back_idx[PTR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            ring[wr_ptr_reg] <= latest;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep && hist_ready)
        begin
            comp_rd_reg <= ring[comp_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            stage_latest_reg <= latest;
            stage_ready_reg  <= hist_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg      <= '0;
            fill_reg        <= '0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            if (keep)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
                fill_reg   <= fill_next;
            end
            if (keep)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (push_ready)
            begin
                stage_valid_reg <= 1'b0;
            end
        end
    end

    assign push_valid      = stage_valid_reg;
    assign push_job.ready  = stage_ready_reg;
    assign push_job.latest = stage_latest_reg;
    assign push_job.comp   = comp_rd_reg;

endmodule

>>> src/rcm_back.sv
// ----------------------------------------------------------------------------
// rcm_back
// Works out the percent change and flags for one close at a time:
// one multiply by the percent scale, then a bit-serial restoring divide.
// ----------------------------------------------------------------------------
module rcm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  rcm_pkg::job_t                     pop_job,
    input  logic [rcm_pkg::CFG_DATA_W-1:0]    flat_epsilon,
    output logic                              result_valid,
    input  logic                              result_ready,
    output rcm_pkg::result_item_t             result_item
);
    import rcm_pkg::*;

    back_state_t state_reg;
    back_state_t state_next;

    logic                  ready_reg;
    logic                  neg_reg;
    logic                  flat_reg;
    logic [PRICE_BITS-1:0] comp_reg;
    logic [PRICE_BITS-1:0] diff_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [PRICE_BITS-1:0] rem_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic                  ovf_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  out_valid_reg;
    result_item_t          out_item_reg;

    logic                  load_out;
    logic                  head_neg;
    logic [PRICE_BITS-1:0] head_diff;
    logic [PRICE_BITS:0]   trial;
    logic                  trial_ge;
    logic [PRICE_BITS:0]   trial_sub;
    logic [QUOT_W-1:0]     pos_pct;
    logic [QUOT_W-1:0]     neg_mag;
    logic [QUOT_W-1:0]     pct;
    logic [PRICE_IN_W-1:0] comp_out;
    result_item_t          item_next;

    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    state_next = pop_job.ready ? BK_MUL : BK_FINISH;
                end
            end
            BK_MUL:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(1))
                begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign head_neg  = pop_job.latest < pop_job.comp;
    assign head_diff = head_neg ? (pop_job.comp - pop_job.latest)
                                : (pop_job.latest - pop_job.comp);

    // one restoring step: remainder stays below the divisor
    assign trial     = {rem_reg, num_reg[NUM_W-1]};
    assign trial_ge  = trial >= {1'b0, comp_reg};
    assign trial_sub = trial - {1'b0, comp_reg};

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    ready_reg <= pop_job.ready;
                    comp_reg  <= pop_job.comp;
                    neg_reg   <= head_neg;
                    diff_reg  <= head_diff;
                end
            end
            BK_MUL:
            begin
                num_reg  <= NUM_W'(diff_reg) * NUM_W'(PCT_SCALE);
                flat_reg <= FLAT_W'(diff_reg) <= FLAT_W'(flat_epsilon);
                rem_reg  <= '0;
                quot_reg <= '0;
                ovf_reg  <= 1'b0;
                step_reg <= STEP_W'(NUM_W);
            end
            BK_DIV:
            begin
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                rem_reg  <= trial_ge ? trial_sub[PRICE_BITS-1:0] : trial[PRICE_BITS-1:0];
                quot_reg <= {quot_reg[QUOT_W-2:0], trial_ge};
                ovf_reg  <= ovf_reg | quot_reg[QUOT_W-1];
                step_reg <= step_reg - 1'b1;
            end
            BK_FINISH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // saturate the magnitude to the signed result range
    assign pos_pct = (ovf_reg || quot_reg[QUOT_W-1]) ? {1'b0, {(QUOT_W-1){1'b1}}} : quot_reg;
    assign neg_mag = (ovf_reg || (quot_reg > {1'b1, {(QUOT_W-1){1'b0}}}))
                     ? {1'b1, {(QUOT_W-1){1'b0}}} : quot_reg;
    assign pct     = (comp_reg == '0) ? '0 : (neg_reg ? ('0 - neg_mag) : pos_pct);

    always_comb
    begin
        for (int i = 0; i < PRICE_IN_W; i++)
        begin
            comp_out[i] = (i < PRICE_BITS) ? comp_reg[i] : 1'b0;
        end
    end

    always_comb
    begin
        item_next.history_ready    = ready_reg;
        item_next.comparison_close = ready_reg ? comp_out : '0;
        item_next.percent_change   = ready_reg ? PCT_W'(pct) : '0;
        item_next.is_flat          = ready_reg && flat_reg;
        item_next.is_rising        = ready_reg && !flat_reg && !neg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule
